[design/cst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants and controller/datapath interface types for the column
// sorter.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int VAL_W  = 32;  // sample_value
  localparam int SIDX_W = 6;   // sorted_index
  localparam int CAT_W  = 16;  // category_value
  localparam int TOL_W  = 16;  // tie_tolerance
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_QUANT_MODE = 1'd0;
  localparam logic [CFG_AW-1:0] REG_TIE_TOL    = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic store;       // write incoming sample
    logic col_init;    // start post-processing of a column
    logic scan_rd;     // issue one scan read
    logic link;        // take scan winner as next sorted element
    logic final_emit;  // emit last sorted element
    logic cat_rd;      // read next sample, categorical pass
    logic cat_emit;    // emit rounded sample
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode;      // quantitative when set
    logic ptr_last;  // read pointer at last stored entry
    logic pos_last;  // current scan is the final one
    logic cur_f;     // a sorted element is waiting for its successor
    logic out_free;  // output register can take a beat
    logic rd_last;   // read data is the last stored entry
  } sts_t;

endpackage

[design/cst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/cst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: column load, repeated min-scans for the sort, categorical pass.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  cst_pkg::sts_t sts,
  output cst_pkg::cmd_t cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_CEM   = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (in_tlast) begin
            cmd.col_init = 1'b1;
            state_nxt = sts.mode ? S_SCAN : S_CRD;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (!sts.cur_f || sts.out_free) begin
          cmd.link  = 1'b1;
          state_nxt = sts.pos_last ? S_FINAL : S_SCAN;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.final_emit = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_CRD: begin
        cmd.cat_rd = 1'b1;
        state_nxt  = S_CEM;
      end
      S_CEM: begin
        if (sts.out_free) begin
          cmd.cat_emit = 1'b1;
          state_nxt = sts.rd_last ? S_LOAD : S_CRD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/cst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp
// Datapath: sample store, min-scan compare, tie test, rounding, output reg.
// ----------------------------------------------------------------------------
module cst_dp #(
  parameter int DEPTH = cst_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [cst_pkg::VAL_W-1:0]  sample_value,
  input  logic                              cfg_tvalid,
  input  logic [cst_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [cst_pkg::TOL_W-1:0]         cfg_data,
  input  cst_pkg::cmd_t                     cmd,
  output cst_pkg::sts_t                     sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic                              out_tlast,
  output logic [cst_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = cst_pkg::VAL_W;
  localparam int SW = cst_pkg::SIDX_W;
  localparam int KW = cst_pkg::CAT_W;
  localparam int TW = cst_pkg::TOL_W;

  // configuration
  logic          mode_r;
  logic [TW-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      tol_r  <= TW'(1);
    end else if (cfg_tvalid) begin
      if (cfg_addr == cst_pkg::REG_QUANT_MODE) begin
        mode_r <= cfg_data[0];
      end
      if (cfg_addr == cst_pkg::REG_TIE_TOL) begin
        tol_r <= cfg_data;
      end
    end
  end

  // sample memory
  logic [CW-1:0]        cnt_r, ptr_r, pos_r;
  logic signed [VW-1:0] rdata;
  logic                 we, re;

  assign we = cmd.store && (cnt_r < CW'(DEPTH));
  assign re = cmd.scan_rd || cmd.cat_rd;

  cst_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vals (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (sample_value),
    .re    (re),
    .raddr (ptr_r[IW-1:0]),
    .rdata (rdata)
  );

  // scan state
  logic                 rd_vld_r, rd_last_r;
  logic [IW-1:0]        rd_idx_r;
  logic signed [VW-1:0] best_v_r, bnd_v_r, cur_v_r;
  logic [IW-1:0]        best_i_r, bnd_i_r, cur_i_r;
  logic                 best_f_r, bnd_f_r, cur_f_r, cur_tie_r;
  logic                 cand, better, ptr_last, close;

  assign ptr_last = (ptr_r == cnt_r - CW'(1));
  assign cand   = !bnd_f_r || (rdata > bnd_v_r) || ((rdata == bnd_v_r) && (rd_idx_r > bnd_i_r));
  assign better = !best_f_r || (rdata < best_v_r);

  // |cur - best| < tolerance
  logic signed [VW:0] diff;
  logic [VW:0]        adiff;
  assign diff  = {cur_v_r[VW-1], cur_v_r} - {best_v_r[VW-1], best_v_r};
  assign adiff = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
  assign close = adiff < {{(VW+1-TW){1'b0}}, tol_r};

  // round half away from zero, saturate
  logic [VW:0]          mag, rnd;
  logic signed [KW-1:0] cat_v;
  assign mag = rdata[VW-1] ? (~{1'b1, rdata} + (VW+1)'(1)) : {1'b0, rdata};
  assign rnd = (mag + (VW+1)'(32'h8000)) >> 16;
  always_comb begin
    if (!rdata[VW-1]) begin
      cat_v = (rnd > (VW+1)'(32767)) ? KW'(32767) : rnd[KW-1:0];
    end else begin
      cat_v = KW'(~rnd + (VW+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (we) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.final_emit || (cmd.cat_emit && rd_last_r)) begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_idx_r  <= ptr_r[IW-1:0];
      rd_last_r <= ptr_last;
      ptr_r     <= ptr_r + CW'(1);
    end
    if (rd_vld_r && cand && better) begin
      best_v_r <= rdata;
      best_i_r <= rd_idx_r;
      best_f_r <= 1'b1;
    end
    if (cmd.link) begin
      ptr_r     <= '0;
      best_f_r  <= 1'b0;
      bnd_v_r   <= best_v_r;
      bnd_i_r   <= best_i_r;
      bnd_f_r   <= 1'b1;
      cur_v_r   <= best_v_r;
      cur_i_r   <= best_i_r;
      cur_f_r   <= 1'b1;
      cur_tie_r <= cur_f_r && close;
      pos_r     <= pos_r + CW'(1);
    end
    if (cmd.col_init) begin
      ptr_r    <= '0;
      pos_r    <= '0;
      best_f_r <= 1'b0;
      bnd_f_r  <= 1'b0;
      cur_f_r  <= 1'b0;
    end
  end

  // output register
  logic                 ov_r, ol_r, otie_r;
  logic [SW-1:0]        oidx_r;
  logic signed [KW-1:0] ocat_r;
  logic                 out_free;
  logic [IW+SW-1:0]     cur_i_ext;

  assign out_free  = !ov_r || out_tready;
  assign cur_i_ext = {{SW{1'b0}}, cur_i_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_free) begin
      ov_r <= (cmd.link && cur_f_r) || cmd.final_emit || cmd.cat_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cmd.link || cmd.final_emit) begin
        oidx_r <= cur_i_ext[SW-1:0];
        ocat_r <= '0;
        otie_r <= cur_tie_r || (cmd.link && close);
        ol_r   <= cmd.final_emit;
      end else if (cmd.cat_emit) begin
        oidx_r <= '0;
        ocat_r <= cat_v;
        otie_r <= 1'b0;
        ol_r   <= rd_last_r;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {1'b0, otie_r, ocat_r, oidx_r};

  assign sts.mode     = mode_r;
  assign sts.ptr_last = ptr_last;
  assign sts.pos_last = (pos_r + CW'(1) == cnt_r);
  assign sts.cur_f    = cur_f_r;
  assign sts.out_free = out_free;
  assign sts.rd_last  = rd_last_r;

endmodule

[design/column_sort_with_tie_marks.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_sort_with_tie_marks
// Stable ascending argsort of one column with tie-run marking, or rounding
// of categorical samples.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one beat per Q16.16 sample, in_tlast on the column's last sample.
//    Up to DEPTH samples are kept; extra samples are dropped, but a dropped
//    beat with in_tlast still closes the column. in_tready is high only
//    while a column is being loaded (one beat per cycle).
//  - out_*: one beat per stored sample, out_tlast on the column's last one.
//    Quantitative mode: arrival indices in sorted order plus tie flag.
//    Categorical mode: rounded values in arrival order.
//  - cfg_*: register writes, always ready; write only while idle.
//  - Sorting repeats a min-scan over the sample RAM (one read port, one entry
//    per cycle), one full scan per sorted result.
//    Categorical pass: each sample is read, rounded and emitted in turn.
//  - The first sorted result is registered at the second link (at the final
//    emit for a single sample); each categorical result follows its RAM read.
//  - A stalled out_tready holds the output register and pauses the
//    sequencer; nothing is lost.
//  - Synchronous reset restores mode=quantitative, tolerance=1, empty column.
// ----------------------------------------------------------------------------
module column_sort_with_tie_marks #(
  parameter int DEPTH = cst_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: [31:0] sample_value
  input  logic [cst_pkg::VAL_W-1:0]         in_tdata,
  input  logic                              in_tlast,   // last_sample
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: [5:0] sorted_index, [21:6] category_value, [22] tie_flag, [23] pad
  output logic [cst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,  // last_result
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready,
  input  logic [cst_pkg::CFG_AW-1:0]        cfg_addr,   // 0 mode, 1 tolerance
  input  logic [cst_pkg::TOL_W-1:0]         cfg_data
);

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  assign cfg_tready = 1'b1;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cst_dp #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_value (in_tdata),
    .cfg_tvalid   (cfg_tvalid),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_tlast    (out_tlast),
    .out_tdata    (out_tdata)
  );

endmodule

[design/cst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Port-level assertions for the column sorter.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cst_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_col_closed: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after column end");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

endmodule

bind column_sort_with_tie_marks cst_checker u_cst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/tb_column_sort_with_tie_marks.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_sort_with_tie_marks
// Self-checking bench for the column sorter. Columns of Q16.16 samples are
// streamed in, and every output beat is checked against a local model that
// does a stable argsort with tie-run marking, or half-away rounding in
// categorical mode. A short table of directed columns comes first. Random
// columns follow, under several register settings and with random stalls
// on both streams.
// ----------------------------------------------------------------------------
module tb_column_sort_with_tie_marks;

  localparam int NDEPTH = 64;
  localparam int ITEMS  = 300;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [cst_pkg::VAL_W-1:0]       in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // [5:0] index, [21:6] category, [22] tie
  logic [cst_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;   // last result of the column
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_tvalid = 1'b0;
  logic                            cfg_tready;
  logic [cst_pkg::CFG_AW-1:0]      cfg_addr = '0;
  logic [cst_pkg::TOL_W-1:0]       cfg_data = '0;

  column_sort_with_tie_marks #(.DEPTH(NDEPTH)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One expected output beat
  typedef struct {
    logic [cst_pkg::SIDX_W-1:0]       idx;
    logic signed [cst_pkg::CAT_W-1:0] cat;
    logic                             tie;
    logic                             last;
  } result_t;

  // Directed stimulus row; chk marks a single-sample column whose only
  // result is typed in here
  typedef struct {
    logic                       mode;
    logic [cst_pkg::TOL_W-1:0]  tol;
    logic [cst_pkg::VAL_W-1:0]  val;
    logic                       last;
    logic                       chk;
    logic [cst_pkg::SIDX_W-1:0] e_idx;
    logic [cst_pkg::CAT_W-1:0]  e_cat;
    logic                       e_tie;
  } row_t;

  result_t                          pending_results[$];
  logic signed [cst_pkg::VAL_W-1:0] column_vals[$];
  logic                             mode_q = 1'b1;
  logic [cst_pkg::TOL_W-1:0]        tol_q  = 16'd1;
  int                               errors = 0;
  int                               beats_in = 0;
  int                               beats_out = 0;
  int                               columns = 0;
  int                               cat_columns = 0;
  int                               overflow_columns = 0;
  bit                               quiet = 1'b0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic signed [cst_pkg::CAT_W-1:0] round_half_away(
    logic signed [cst_pkg::VAL_W-1:0] v);
    longint r;
    if (v >= 0) r = (longint'(v) + 64'h8000) >>> 16;
    else        r = -((-longint'(v) + 64'h8000) >>> 16);
    if (r > 32767)  r = 32767;
    if (r < -32768) r = -32768;
    return r[cst_pkg::CAT_W-1:0];
  endfunction

  // Close the current column: stable argsort or rounding, queued as beats
  task automatic close_column();
    int      n;
    int      order[NDEPTH];
    bit      tie[NDEPTH];
    int      j;
    int      key;
    longint  d;
    result_t r;
    n = column_vals.size();
    columns++;
    if (!mode_q) cat_columns++;
    if (mode_q) begin
      for (int i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && column_vals[order[j-1]] > column_vals[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        tie[i] = 1'b0;
      end
      for (int k = 0; k + 1 < n; k++) begin
        d = longint'(column_vals[order[k]]) - longint'(column_vals[order[k+1]]);
        if (d < 0) d = -d;
        if (d < longint'(tol_q)) begin
          tie[k]   = 1'b1;
          tie[k+1] = 1'b1;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      key   = mode_q ? order[k] : 0;
      r.idx = key[cst_pkg::SIDX_W-1:0];
      r.cat = mode_q ? '0 : round_half_away(column_vals[k]);
      r.tie = mode_q ? tie[k] : 1'b0;
      r.last = (k + 1 == n);
      pending_results = {pending_results, r};
    end
    column_vals.delete();
  endtask

  // Sample beat with an optional random gap in front of it
  task automatic send_sample(logic [cst_pkg::VAL_W-1:0] v, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    beats_in++;
    if (column_vals.size() < NDEPTH) column_vals = {column_vals, v};
    if (last) close_column();
  endtask

  // Leaves cfg_tvalid high; the caller drops it after the last write
  task automatic write_reg(logic [cst_pkg::CFG_AW-1:0] a, logic [cst_pkg::TOL_W-1:0] d);
    in_tvalid  <= 1'b0;
    cfg_tvalid <= 1'b1;
    cfg_addr   <= a;
    cfg_data   <= d;
    do @(posedge clk); while (!cfg_tready);
    if (a == cst_pkg::REG_QUANT_MODE) mode_q = d[0];
    else                              tol_q  = d;
  endtask

  // Registers change only with the block idle: all results back, then a
  // wait for the sequencer to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic m, logic [cst_pkg::TOL_W-1:0] t);
    if (m == mode_q && t == tol_q) return;
    wait_idle();
    write_reg(cst_pkg::REG_QUANT_MODE, {15'd0, m});
    write_reg(cst_pkg::REG_TIE_TOL, t);
    cfg_tvalid <= 1'b0;
  endtask

  // Receiver: random stall bursts, always ready near the end
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Output checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, data", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[5:0] !== want.idx)
          report_mismatch("sorted_index", out_tdata[5:0], want.idx);
        if ($signed(out_tdata[21:6]) !== want.cat)
          report_mismatch("category_value", $signed(out_tdata[21:6]), want.cat);
        if (out_tdata[22] !== want.tie)
          report_mismatch("tie_flag", out_tdata[22], want.tie);
        if (out_tlast !== want.last)
          report_mismatch("last_result", out_tlast, want.last);
      end
    end
  end

  // Directed columns
  row_t dir_rows[] = '{
    // single sample after reset
    '{1'b1, 16'd1,     32'h0001_0000, 1'b1, 1'b1, 6'd0, 16'd0, 1'b0},
    // stable order of equal values, tolerance 1
    '{1'b1, 16'd1,     32'h0000_0005, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'd1,     32'h0000_0003, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'd1,     32'h0000_0005, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'd1,     32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0, 16'd0, 1'b0},
    // zero tolerance: no ties even on equal values
    '{1'b1, 16'd0,     32'h0000_0007, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'd0,     32'h0000_0007, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'd0,     32'h0000_0007, 1'b1, 1'b0, 6'd0, 16'd0, 1'b0},
    // full-scale values, widest tolerance
    '{1'b1, 16'hFFFF,  32'h8000_0000, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'hFFFF,  32'h7FFF_FFFF, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'hFFFF,  32'h8000_0064, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b1, 16'hFFFF,  32'h7FFF_0000, 1'b1, 1'b0, 6'd0, 16'd0, 1'b0},
    // categorical: positive saturation, negative extreme, zero
    '{1'b0, 16'hFFFF,  32'h7FFF_FFFF, 1'b1, 1'b1, 6'd0, 16'h7FFF, 1'b0},
    '{1'b0, 16'hFFFF,  32'h8000_0000, 1'b1, 1'b1, 6'd0, 16'h8000, 1'b0},
    '{1'b0, 16'hFFFF,  32'h0000_0000, 1'b1, 1'b1, 6'd0, 16'h0000, 1'b0},
    // halves round away from zero
    '{1'b0, 16'hFFFF,  32'h0000_8000, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b0, 16'hFFFF,  32'hFFFF_8000, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b0, 16'hFFFF,  32'h0000_7FFF, 1'b0, 1'b0, 6'd0, 16'd0, 1'b0},
    '{1'b0, 16'hFFFF,  32'hFFFF_7FFF, 1'b1, 1'b0, 6'd0, 16'd0, 1'b0}
  };

  initial begin
    int                        len;
    int                        pick;
    logic [cst_pkg::VAL_W-1:0] base;
    logic [cst_pkg::VAL_W-1:0] v;
    logic [cst_pkg::TOL_W-1:0] t;
    result_t                   typed;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      set_regs(dir_rows[i].mode, dir_rows[i].tol);
      send_sample(dir_rows[i].val, dir_rows[i].last);
      if (dir_rows[i].chk) begin
        // swap in the hand-written result for this one-sample column
        typed = pending_results.pop_back();
        typed.idx = dir_rows[i].e_idx;
        typed.cat = dir_rows[i].e_cat;
        typed.tie = dir_rows[i].e_tie;
        pending_results = {pending_results, typed};
      end
    end

    // Random phases: new settings, then a handful of columns each
    while (beats_in < ITEMS) begin
      pick = $urandom_range(0, 3);
      t = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
          (pick == 2) ? 16'hFFFF : 16'($urandom());
      set_regs($urandom_range(0, 3) != 0, t);
      repeat ($urandom_range(2, 5)) begin
        if (beats_in < ITEMS) begin
          pick = $urandom_range(0, 29);
          if (pick == 0)      len = NDEPTH;
          else if (pick == 1) begin
            len = $urandom_range(NDEPTH + 1, NDEPTH + 6);
            overflow_columns++;
          end else            len = $urandom_range(1, 8);
          quiet = (beats_in > ITEMS - 50);
          base = $urandom();
          for (int s = 0; s < len; s++) begin
            // clustered values make tie runs; the rest span the full range
            if ($urandom_range(0, 2) == 0) v = $urandom();
            else v = base + 32'($urandom_range(0, 3)) - 32'($urandom_range(0, 3));
            send_sample(v, s == len - 1);
          end
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d columns (%0d categorical, %0d overflowing), %0d beats in, %0d out",
             columns, cat_columns, overflow_columns, beats_in, beats_out);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
design/cst_pkg.sv
design/cst_ram.sv
design/cst_ctrl.sv
design/cst_dp.sv
design/column_sort_with_tie_marks.sv
design/cst_checker.sv
tb/tb_column_sort_with_tie_marks.sv
